// ===== rtl/core/tanc_pkg.sv =====
// shared types, constants and helper functions of the temporal aa neighborhood clamp
`timescale 1ns / 1ps
`default_nettype none

package tanc_pkg;

    localparam int MAX_WIDTH_DEF = 2048;

    // configuration register widths and port layout
    localparam int FW_W       = 12;
    localparam int FH_W       = 13;
    localparam int HW_W       = 9;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HISTORY_WEIGHT = 2'd2;

    localparam logic [FW_W-1:0] FW_RESET = 12'd1024;
    localparam logic [FH_W-1:0] FH_RESET = 13'd768;
    localparam logic [HW_W-1:0] HW_RESET = 9'd230;

    // frame limits
    localparam int W_MIN  = 3;
    localparam int H_MIN  = 3;
    localparam int H_MAX  = 4096;
    localparam int W_FULL = 256;
    localparam int ROW_W  = 13;

    // result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_CNT_W = 4;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    typedef struct packed {
        rgb_t lo;
        rgb_t hi;
    } box_t;

    // one line-store entry: last line, the line before, history of last line
    typedef struct packed {
        rgb_t line_a;
        rgb_t line_b;
        rgb_t hist;
    } mem_word_t;

    // per-item control handed from the counters to the window stage
    typedef struct packed {
        logic valid;
        logic upd;
        logic emit0;
        logic emit1;
        logic first1;
        logic fe;
        logic drain;
        logic top_a;
    } s1_ctl_t;

    // snapshot of one center pixel on its way to the blend
    typedef struct packed {
        logic valid;
        logic fe;
        rgb_t centre;
        rgb_t hist;
        box_t box0;
        box_t box1;
        box_t box2;
    } s2_item_t;

    typedef struct packed {
        logic fe;
        rgb_t pix;
    } result_t;

    function automatic rgb_t rgb_min(input rgb_t x, input rgb_t y);
        rgb_t m;
        m.red   = (x.red   < y.red)   ? x.red   : y.red;
        m.green = (x.green < y.green) ? x.green : y.green;
        m.blue  = (x.blue  < y.blue)  ? x.blue  : y.blue;
        return m;
    endfunction

    function automatic rgb_t rgb_max(input rgb_t x, input rgb_t y);
        rgb_t m;
        m.red   = (x.red   > y.red)   ? x.red   : y.red;
        m.green = (x.green > y.green) ? x.green : y.green;
        m.blue  = (x.blue  > y.blue)  ? x.blue  : y.blue;
        return m;
    endfunction

    function automatic logic [7:0] chan_clamp(input logic [7:0] v, input logic [7:0] lo,
                                              input logic [7:0] hi);
        logic [7:0] r;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tanc_line_mem.sv =====
// line store memory: two previous lines and the delayed history, one entry per column
`timescale 1ns / 1ps
`default_nettype none

module tanc_line_mem
    import tanc_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int AW = $clog2(MAX_WIDTH)
)(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output mem_word_t     rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  mem_word_t     wr_data
);

    mem_word_t mem [0:MAX_WIDTH-1];
    mem_word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tanc_ctrl.sv =====
// raster position counters, item decode and the memory read request
`timescale 1ns / 1ps
`default_nettype none

module tanc_ctrl
    import tanc_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int AW = $clog2(MAX_WIDTH)
)(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_ready,
    input  logic            in_flush,
    input  rgb_t            in_cur,
    input  rgb_t            in_hist,
    input  logic [FW_W-1:0] frame_width,
    input  logic [FH_W-1:0] frame_height,
    output logic            rd_en,
    output logic [AW-1:0]   rd_addr,
    output s1_ctl_t         s1_ctl,
    output logic [AW-1:0]   s1_addr,
    output rgb_t            s1_cur,
    output rgb_t            s1_hist
);

    localparam int WW        = $clog2(MAX_WIDTH + 1);
    localparam int CW        = (WW > FW_W) ? WW : FW_W;
    localparam int ROW_LIMIT = H_MAX + 1;

    logic [AW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CW-1:0]    fw_ext;
    logic [WW-1:0]    width_eff;
    logic [ROW_W-1:0] fh_ext;
    logic [ROW_W-1:0] height_eff;
    logic [WW-1:0]    col_inc;
    logic             acc, ign, emit0, fe_now, emit1;
    s1_ctl_t          s1_ctl_reg, s1_ctl_next;
    logic [AW-1:0]    s1_addr_reg;
    rgb_t             s1_cur_reg, s1_hist_reg;

    always_comb
    begin
        fw_ext = CW'(frame_width);
        if (fw_ext < CW'(W_MIN))
        begin
            width_eff = WW'(W_MIN);
        end
        else if (fw_ext > CW'(MAX_WIDTH))
        begin
            width_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            width_eff = WW'(fw_ext);
        end

        fh_ext = ROW_W'(frame_height);
        if (fh_ext < ROW_W'(H_MIN))
        begin
            height_eff = ROW_W'(H_MIN);
        end
        else if (fh_ext > ROW_W'(H_MAX))
        begin
            height_eff = ROW_W'(H_MAX);
        end
        else
        begin
            height_eff = fh_ext;
        end
    end

    assign acc     = in_valid && in_ready;
    // flush items are dropped while real lines are still arriving
    assign ign     = (row_reg < height_eff) && in_flush;
    // start of a line closes the right-edge center of two lines up
    assign emit0   = (col_reg == '0) && (row_reg >= ROW_W'(2));
    assign fe_now  = emit0 && (row_reg >= height_eff + ROW_W'(1));
    assign emit1   = (col_reg != '0) && (row_reg != '0) && (row_reg <= height_eff);
    assign col_inc = WW'(col_reg) + WW'(1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (acc && !ign)
        begin
            if (fe_now)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_inc >= width_eff)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = AW'(col_inc);
            end
        end
    end

    always_comb
    begin
        s1_ctl_next.valid  = acc && !ign;
        s1_ctl_next.upd    = !fe_now;
        s1_ctl_next.emit0  = emit0;
        s1_ctl_next.emit1  = emit1;
        s1_ctl_next.first1 = (col_reg == AW'(1));
        s1_ctl_next.fe     = fe_now;
        s1_ctl_next.drain  = (row_reg >= height_eff);
        s1_ctl_next.top_a  = (row_reg <= ROW_W'(1));
    end

    assign rd_en   = acc && !ign && !fe_now;
    assign rd_addr = col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            s1_ctl_reg <= '0;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            s1_ctl_reg <= s1_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_addr_reg <= col_reg;
            s1_cur_reg  <= in_cur;
            s1_hist_reg <= in_hist;
        end
    end

    assign s1_ctl  = s1_ctl_reg;
    assign s1_addr = s1_addr_reg;
    assign s1_cur  = s1_cur_reg;
    assign s1_hist = s1_hist_reg;

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && fe_now) |=> (col_reg == '0 && row_reg == '0))
        else $error("position counters not cleared after the frame end transaction");

    a_flush_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && ign) |=> ($stable(col_reg) && $stable(row_reg) && !s1_ctl_reg.valid))
        else $error("flush transaction during active lines changed state");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= ROW_W'(ROW_LIMIT))
        else $error("row counter ran past the drain line");

endmodule

`default_nettype wire

// ===== rtl/core/tanc_window.sv =====
// 3x3 window kept as per-column min/max boxes, line store write-back and center snapshot
`timescale 1ns / 1ps
`default_nettype none

module tanc_window
    import tanc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  s1_ctl_t   s1_ctl,
    input  rgb_t      s1_cur,
    input  rgb_t      s1_hist,
    input  mem_word_t rd_data,
    output logic      wr_en,
    output mem_word_t wr_data,
    output s2_item_t  s2
);

    rgb_t     pix_a, pix_b, pix_cur, pix_top;
    box_t     new_box;
    box_t     col_old_reg, col_new_reg;
    rgb_t     mid_reg, hold_reg;
    logic     early, full;
    s2_item_t s2_reg, s2_next;

    always_comb
    begin
        pix_a   = rd_data.line_a;
        pix_b   = rd_data.line_b;
        // drain lines repeat the bottom line, the first two lines repeat the top
        pix_cur = s1_ctl.drain ? pix_a : s1_cur;
        pix_top = s1_ctl.top_a ? pix_a : pix_b;

        new_box.lo = rgb_min(rgb_min(pix_top, pix_a), pix_cur);
        new_box.hi = rgb_max(rgb_max(pix_top, pix_a), pix_cur);

        wr_data.line_a = pix_cur;
        wr_data.line_b = pix_a;
        wr_data.hist   = s1_hist;
    end

    assign wr_en = s1_ctl.valid && s1_ctl.upd;
    assign early = s1_ctl.emit1 && s1_ctl.first1;
    assign full  = s1_ctl.emit1 && !s1_ctl.first1;

    // left edge uses two columns, right edge (line start) uses the stored two
    always_comb
    begin
        s2_next.valid  = s1_ctl.valid && (s1_ctl.emit0 || s1_ctl.emit1);
        s2_next.fe     = s1_ctl.fe;
        s2_next.centre = mid_reg;
        s2_next.hist   = hold_reg;
        s2_next.box0   = early ? col_new_reg : col_old_reg;
        s2_next.box1   = early ? new_box : col_new_reg;
        s2_next.box2   = full ? new_box : s2_next.box1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_old_reg <= '0;
            col_new_reg <= '0;
            mid_reg     <= '0;
            hold_reg    <= '0;
            s2_reg      <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                col_old_reg <= col_new_reg;
                col_new_reg <= new_box;
                mid_reg     <= pix_a;
                hold_reg    <= rd_data.hist;
            end
            s2_reg <= s2_next;
        end
    end

    assign s2 = s2_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tanc_blend.sv =====
// history clamp to the neighborhood box and weighted blend with the center pixel
`timescale 1ns / 1ps
`default_nettype none

module tanc_blend
    import tanc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  s2_item_t        s2,
    input  logic [HW_W-1:0] weight,
    output logic            push,
    output result_t         res
);

    rgb_t            lo_min, hi_max, h_clamp;
    logic [HW_W-1:0] w_eff;
    logic            s3_valid_reg;
    logic            s3_fe_reg;
    rgb_t            s3_centre_reg, s3_hist_reg;

    // cv*(256-w) + h*w + 128 rewritten as cv*256 + (h-cv)*w + 128
    function automatic logic [7:0] blend_chan(input logic [7:0] cv, input logic [7:0] hv,
                                              input logic [HW_W-1:0] w);
        logic signed [8:0]  diff;
        logic signed [9:0]  wsg;
        logic signed [18:0] prod;
        logic [19:0]        sum;
        diff = $signed({1'b0, hv}) - $signed({1'b0, cv});
        wsg  = $signed({1'b0, w});
        prod = diff * wsg;
        sum  = {4'b0000, cv, 8'h00} + {prod[18], prod} + 20'd128;
        return sum[15:8];
    endfunction

    always_comb
    begin
        lo_min = rgb_min(rgb_min(s2.box0.lo, s2.box1.lo), s2.box2.lo);
        hi_max = rgb_max(rgb_max(s2.box0.hi, s2.box1.hi), s2.box2.hi);
        h_clamp.red   = chan_clamp(s2.hist.red,   lo_min.red,   hi_max.red);
        h_clamp.green = chan_clamp(s2.hist.green, lo_min.green, hi_max.green);
        h_clamp.blue  = chan_clamp(s2.hist.blue,  lo_min.blue,  hi_max.blue);
    end

    assign w_eff = (weight > HW_W'(W_FULL)) ? HW_W'(W_FULL) : weight;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_fe_reg     <= s2.fe;
        s3_centre_reg <= s2.centre;
        s3_hist_reg   <= h_clamp;
    end

    always_comb
    begin
        res.fe        = s3_fe_reg;
        res.pix.red   = blend_chan(s3_centre_reg.red,   s3_hist_reg.red,   w_eff);
        res.pix.green = blend_chan(s3_centre_reg.green, s3_hist_reg.green, w_eff);
        res.pix.blue  = blend_chan(s3_centre_reg.blue,  s3_hist_reg.blue,  w_eff);
    end

    assign push = s3_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tanc_out_fifo.sv =====
// small result queue in front of the output channel
`timescale 1ns / 1ps
`default_nettype none

module tanc_out_fifo
    import tanc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  result_t               push_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output result_t               out_data,
    output logic [FIFO_CNT_W-1:0] count
);

    localparam int PW = $clog2(FIFO_DEPTH);

    result_t               fifo_mem [0:FIFO_DEPTH-1];
    logic [PW-1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_data  = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + FIFO_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

`default_nettype wire

// ===== rtl/core/temporal_aa_neighborhood_clamp_top.sv =====
// Temporal anti-aliasing with 3x3 neighborhood clamp on a raster pixel stream.
// Input channel (s_axis): one transaction per pixel carrying the current and the
// history color of the same position; tuser marks a flush transaction. Each frame is
// frame_width*frame_height pixels followed by frame_width+1 flush transactions.
// Output channel (m_axis): blended color of the center pixel, tlast on the last pixel.
// The center (r, c) is produced by the input at (r+1, c+1); the right-edge pixel of a
// line is produced by the first input of the line two below. A result passes the control,
// window and blend registers and the result queue on its way to m_axis.
// Throughput: one transaction per clock while s_axis_tready is high. Each pixel does
// one read and one write of the single line memory (two lines plus delayed history
// per column), read at accept and written back the next cycle.
// Reset: counters and window clear, registers take their defaults (1024 x 768,
// weight 230); the line memory is not cleared and needs no pass.
// Stall: results wait in an 8-entry queue; s_axis_tready drops when the queue plus the
// results still in the pipeline would fill it, and rises as m_axis drains.
// Configuration writes (cfg_we, cfg_addr, cfg_wdata) take effect at once and are
// meant for idle periods.
`timescale 1ns / 1ps
`default_nettype none

module temporal_aa_neighborhood_clamp_top
    import tanc_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // cur_red, cur_green, cur_blue, hist_red, hist_green, hist_blue
    input  logic [47:0]           s_axis_tdata,
    // flush
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_red, out_green, out_blue
    output logic [23:0]           m_axis_tdata,
    output logic                  m_axis_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic [FW_W-1:0]       frame_width_reg;
    logic [FH_W-1:0]       frame_height_reg;
    logic [HW_W-1:0]       history_weight_reg;

    rgb_t                  in_cur, in_hist;
    logic                  rd_en, wr_en;
    logic [AW-1:0]         rd_addr, s1_addr;
    mem_word_t             rd_data, wr_data;
    s1_ctl_t               s1_ctl;
    rgb_t                  s1_cur, s1_hist;
    s2_item_t              s2;
    logic                  push;
    result_t               res, out_res;
    logic [FIFO_CNT_W-1:0] fifo_count, pending;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= FW_RESET;
            frame_height_reg   <= FH_RESET;
            history_weight_reg <= HW_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_FRAME_WIDTH:    frame_width_reg    <= cfg_wdata[FW_W-1:0];
                CFG_FRAME_HEIGHT:   frame_height_reg   <= cfg_wdata[FH_W-1:0];
                CFG_HISTORY_WEIGHT: history_weight_reg <= cfg_wdata[HW_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign in_cur  = s_axis_tdata[23:0];
    assign in_hist = s_axis_tdata[47:24];

    // results already queued or still on their way decide whether a new pixel fits
    assign pending = fifo_count
                   + FIFO_CNT_W'(s1_ctl.valid && (s1_ctl.emit0 || s1_ctl.emit1))
                   + FIFO_CNT_W'(s2.valid)
                   + FIFO_CNT_W'(push);
    assign s_axis_tready = (pending < FIFO_CNT_W'(FIFO_DEPTH));

    tanc_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_flush     (s_axis_tuser),
        .in_cur       (in_cur),
        .in_hist      (in_hist),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .s1_ctl       (s1_ctl),
        .s1_addr      (s1_addr),
        .s1_cur       (s1_cur),
        .s1_hist      (s1_hist)
    );

    tanc_line_mem #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (s1_addr),
        .wr_data (wr_data)
    );

    tanc_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .s1_ctl  (s1_ctl),
        .s1_cur  (s1_cur),
        .s1_hist (s1_hist),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .s2      (s2)
    );

    tanc_blend u_blend (
        .clk    (clk),
        .rst_n  (rst_n),
        .s2     (s2),
        .weight (history_weight_reg),
        .push   (push),
        .res    (res)
    );

    tanc_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_res),
        .count     (fifo_count)
    );

    assign m_axis_tdata = out_res.pix;
    assign m_axis_tlast = out_res.fe;

endmodule

`default_nettype wire
